// ===== src/merge_sorter_top_macros.svh =====
// Assertion macros for the merge sorter checker.
// Expects clk and rst in the scope of each use.
`ifndef MERGE_SORTER_TOP_MACROS_SVH
`define MERGE_SORTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge_sorter_top: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge_sorter_top: next-cycle check failed");

`endif

// ===== src/ms_pkg.sv =====
// Shared constants and types for the merge sorter.
// No dependencies.
`timescale 1ns / 1ps

package ms_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         addr_t;

  // accepted input transaction
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  last;
  } in_xact_t;

  // result offered by the sort core
  typedef struct packed {
    logic  valid;
    data_t value;
    logic  last;
    logic  ovf;
  } out_xact_t;

endpackage

// ===== src/ms_sort_core.sv =====
// Sort core: both list stores, load path, merge sequencer and readout.
// Depends on ms_pkg.
`timescale 1ns / 1ps

module ms_sort_core
  import ms_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_xact_t  in_x,
  output logic      load_ready,
  output out_xact_t out_x,
  input  logic      out_ready
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SETUP = 5'b00010,
    S_MERGE = 5'b00100,
    S_PRIME = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;
  cnt_t   count, count_next;
  logic   dropped, dropped_next;
  cnt_t   n, n_next;
  cnt_t   w, w_next;
  cnt_t   lo, lo_next;
  cnt_t   mid, mid_next;
  cnt_t   hi, hi_next;
  cnt_t   i, i_next;
  cnt_t   j, j_next;
  cnt_t   k, k_next;
  logic   src_b, src_b_next;

  data_t mem_a [CAPACITY];
  data_t mem_b [CAPACITY];
  data_t ra0, ra1, rb0, rb1;
  data_t rd0, rd1;

  logic     has_room;
  logic     a_ok, b_ok, take_a;
  data_t    wr_val;
  logic [CNT_W:0] lo_w, lo_2w, w2;
  cnt_t     setup_mid, setup_hi;
  cnt_t     load_n;
  logic     out_last;

  logic     we_a, we_b;
  addr_t    wa_addr, wb_addr, addr0, addr1;
  data_t    wa_data;

  assign has_room   = count < CNT_W'(CAPACITY);
  assign load_ready = (state == S_LOAD);

  // src store is mem_b when src_b is set
  assign rd0 = src_b ? rb0 : ra0;
  assign rd1 = src_b ? rb1 : ra1;

  assign a_ok   = i < mid;
  assign b_ok   = j < hi;
  assign take_a = a_ok && (!b_ok || (rd0 < rd1));
  assign wr_val = take_a ? rd0 : rd1;

  assign lo_w      = {1'b0, lo} + {1'b0, w};
  assign lo_2w     = {1'b0, lo} + {w, 1'b0};
  assign w2        = {w, 1'b0};
  assign setup_mid = (lo_w  >= {1'b0, n}) ? n : lo_w[CNT_W-1:0];
  assign setup_hi  = (lo_2w >= {1'b0, n}) ? n : lo_2w[CNT_W-1:0];
  assign load_n    = has_room ? count + CNT_W'(1) : count;
  assign out_last  = (i == n - CNT_W'(1));

  assign out_x.valid = (state == S_OUT);
  assign out_x.value = rd0;
  assign out_x.last  = out_last;
  assign out_x.ovf   = dropped;

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    n_next       = n;
    w_next       = w;
    lo_next      = lo;
    mid_next     = mid;
    hi_next      = hi;
    i_next       = i;
    j_next       = j;
    k_next       = k;
    src_b_next   = src_b;
    unique case (state)
      S_LOAD: begin
        if (in_x.valid) begin
          if (has_room) begin
            count_next = count + CNT_W'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_x.last) begin
            n_next     = load_n;
            count_next = '0;
            w_next     = CNT_W'(1);
            lo_next    = '0;
            src_b_next = 1'b0;
            state_next = (load_n == CNT_W'(1)) ? S_PRIME : S_SETUP;
          end
        end
      end
      S_SETUP: begin
        mid_next   = setup_mid;
        hi_next    = setup_hi;
        i_next     = lo;
        j_next     = setup_mid;
        k_next     = lo;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (take_a) begin
          i_next = i + CNT_W'(1);
        end else begin
          j_next = j + CNT_W'(1);
        end
        k_next = k + CNT_W'(1);
        if (k + CNT_W'(1) == hi) begin
          lo_next    = hi;
          state_next = S_SETUP;
          if (hi == n) begin
            // pass complete: widen runs, swap stores
            lo_next    = '0;
            w_next     = w2[CNT_W-1:0];
            src_b_next = !src_b;
            if (w2 >= {1'b0, n}) begin
              state_next = S_PRIME;
            end
          end
        end
      end
      S_PRIME: begin
        i_next     = '0;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          i_next = i + CNT_W'(1);
          if (out_last) begin
            dropped_next = 1'b0;
            src_b_next   = 1'b0;
            state_next   = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
      src_b   <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      src_b   <= src_b_next;
    end
  end

  always_ff @(posedge clk) begin
    n   <= n_next;
    w   <= w_next;
    lo  <= lo_next;
    mid <= mid_next;
    hi  <= hi_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
  end

  // write ports: mem_a takes loads and merges into A, mem_b merges into B
  assign we_a    = ((state == S_LOAD) && in_x.valid && has_room) ||
                   ((state == S_MERGE) && src_b);
  assign wa_addr = (state == S_LOAD) ? count[IDX_W-1:0] : k[IDX_W-1:0];
  assign wa_data = (state == S_LOAD) ? in_x.value : wr_val;
  assign we_b    = (state == S_MERGE) && !src_b;
  assign wb_addr = k[IDX_W-1:0];

  // read pointers issue from next values so data lines up with i and j
  assign addr0 = i_next[IDX_W-1:0];
  assign addr1 = j_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wa_addr] <= wa_data;
    end
    ra0 <= mem_a[addr0];
    ra1 <= mem_a[addr1];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wb_addr] <= wr_val;
    end
    rb0 <= mem_b[addr0];
    rb1 <= mem_b[addr1];
  end

endmodule

// ===== src/merge_sorter_top.sv =====
// Merge sorter top level: stream ports, sort core and output register.
// Depends on ms_pkg and ms_sort_core.
`timescale 1ns / 1ps

// Sorts a list of up to 64 signed 32-bit values into ascending order.
// The list arrives one value per transaction on the s_ side, one per cycle,
// and ends with the transaction that carries s_tlast. Values past the 64th
// are dropped, and every result of that list then carries m_tuser = 1.
// After the last value the block stops accepting input, sorts with
// bottom-up merge passes (run widths 1, 2, 4, ...) ping-ponging between two
// 64-entry RAMs, and streams the list out on the m_ side, m_tlast on the
// final value. Each pass reads both runs through two read ports of the
// source RAM and writes one merged value per cycle, after a setup step for
// each run pair. Input is taken again once the final result enters the
// output register. Single values skip the merge passes.

module merge_sorter_top
  import ms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  data_t       s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output data_t       m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // final_res
  output logic        m_tuser    // [0] overflow
);

  in_xact_t  in_x;
  out_xact_t out_x;
  logic      out_ready;
  logic      load_ready;

  assign s_tready   = load_ready;
  assign in_x.valid = s_tvalid && load_ready;
  assign in_x.value = s_tdata;
  assign in_x.last  = s_tlast;

  // output slot frees when empty or being taken this cycle
  assign out_ready = !m_tvalid || m_tready;

  ms_sort_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_x       (in_x),
    .load_ready (load_ready),
    .out_x      (out_x),
    .out_ready  (out_ready)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= out_x.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && out_x.valid) begin
      m_tdata <= out_x.value;
      m_tlast <= out_x.last;
      m_tuser <= out_x.ovf;
    end
  end

endmodule

// ===== src/ms_checker.sv =====
// Port-level checks for merge_sorter_top, bound to the top level.
// Depends on merge_sorter_top_macros.svh.
`timescale 1ns / 1ps
`include "merge_sorter_top_macros.svh"

module ms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // list end starts the sort, input closes
  `MS_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready)

  // loading goes on one value per cycle until the list ends
  `MS_ASSERT_NEXT(a_load_continues, s_tvalid && s_tready && !s_tlast, s_tready)

  // no new list is taken while a non-final result is pending
  `MS_ASSERT_SAME(a_no_load_mid_list, m_tvalid && !m_tlast, !s_tready)

  // a stalled result holds its value
  `MS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // and its flags
  `MS_ASSERT_NEXT(a_out_hold_flags, m_tvalid && !m_tready, $stable(m_tlast) && $stable(m_tuser))

endmodule

bind merge_sorter_top ms_checker u_ms_checker (.*);
